@@ design/cbc_pkg.sv @@
`default_nettype none

package cbc_pkg;

  // rom bank register width before parameter clipping
  localparam int unsigned RomBankBitsDef = 7;
  localparam int unsigned BankMaxW       = 7;
  localparam int unsigned RomAddrW       = 21;
  localparam int unsigned AddrW          = 16;
  localparam int unsigned DataW          = 8;

  // apb register map
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam logic        RegCartKind = 1'b0;  // paddr[2] of the cart_kind register

  // cartridge kinds
  typedef enum logic [2:0] {
    KindRom     = 3'd0,
    KindMbc1    = 3'd1,
    KindMbc1Ram = 3'd2,
    KindMbc2    = 3'd3,
    KindMbc2Bat = 3'd4,
    KindMbc3    = 3'd5,
    KindMbc3Ram = 3'd6,
    KindNone    = 3'd7
  } cart_kind_e;

  // banking modes
  typedef enum logic [1:0] {
    ModeRom   = 2'd0,
    ModeRam   = 2'd1,
    ModeClock = 2'd2
  } bank_mode_e;

  // bus access types
  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  // address regions by address[15:13]
  localparam logic [2:0] RgnRamEn  = 3'd0;  // 0x0000-0x1fff
  localparam logic [2:0] RgnBankLo = 3'd1;  // 0x2000-0x3fff
  localparam logic [2:0] RgnBankHi = 3'd2;  // 0x4000-0x5fff
  localparam logic [2:0] RgnMode   = 3'd3;  // 0x6000-0x7fff
  localparam logic [2:0] RgnExtRam = 3'd5;  // 0xa000-0xbfff

  localparam logic [3:0] RamEnKey   = 4'hA;
  localparam logic [6:0] Mbc2RamTop = 7'h50;  // address[15:9] of 0xa000-0xa1ff
  localparam logic [7:0] Mbc3ModeRamMax   = 8'h07;
  localparam logic [7:0] Mbc3ModeClockMax = 8'h0C;

  // one bus access
  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } cbc_req_t;

  // one result word
  typedef struct packed {
    logic                write_through;
    logic                access_fault;
    logic [RomAddrW-1:0] rom_address;
    logic [BankMaxW-1:0] rom_bank_now;
    logic                ram_enabled_now;
    bank_mode_e          bank_mode_now;
  } cbc_rsp_t;

endpackage

`default_nettype wire

@@ design/cartridge_bank_controller_core.sv @@
// a result word is registered and presented in the cycle after its bus access is accepted
// throughput: one access per cycle while out_ready_i is high; the single output register refills as it drains
// the bank decode and state update are one level of logic in front of that register
// reset (rst_ni low, asynchronous): rom bank 1, ram disabled, rom banking mode,
// cart kind plain rom, output register empty
`default_nettype none

module cartridge_bank_controller_core
  import cbc_pkg::*;
#(
  parameter int unsigned ROM_BANK_BITS = RomBankBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // access channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                req_type_i,
  input  wire logic [AddrW-1:0]    address_i,
  input  wire logic [DataW-1:0]    write_data_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     write_through_o,
  output logic                     access_fault_o,
  output logic [RomAddrW-1:0]      rom_address_o,
  output logic [BankMaxW-1:0]      rom_bank_now_o,
  output logic                     ram_enabled_now_o,
  output logic [1:0]               bank_mode_now_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PaddrW-1:0]   paddr,
  input  wire logic [PdataW-1:0]   pwdata,
  output logic [PdataW-1:0]        prdata,
  output logic                     pready
);

  cart_kind_e cart_kind;
  cbc_req_t   req;
  cbc_rsp_t   rsp, rsp_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign req.req_type   = req_type_i;
  assign req.address    = address_i;
  assign req.write_data = write_data_i;

  cbc_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cart_kind_o (cart_kind)
  );

  cbc_mapper #(
    .ROM_BANK_BITS (ROM_BANK_BITS)
  ) u_mapper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req),
    .cart_kind_i (cart_kind),
    .rsp_o       (rsp)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign write_through_o   = rsp_q.write_through;
  assign access_fault_o    = rsp_q.access_fault;
  assign rom_address_o     = rsp_q.rom_address;
  assign rom_bank_now_o    = rsp_q.rom_bank_now;
  assign ram_enabled_now_o = rsp_q.ram_enabled_now;
  assign bank_mode_now_o   = rsp_q.bank_mode_now;

  a_valid_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result word appeared without an accepted access");

endmodule

`default_nettype wire

@@ design/cbc_apb_regs.sv @@
`default_nettype none

module cbc_apb_regs
  import cbc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output cart_kind_e             cart_kind_o
);

  cart_kind_e kind_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegCartKind);

  // cart kind register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindRom;
    end else if (wr_en) begin
      kind_q <= cart_kind_e'(pwdata[2:0]);
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegCartKind) begin
      prdata = {{(PdataW-3){1'b0}}, kind_q};
    end
  end

  assign cart_kind_o = kind_q;

  a_kind_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(kind_q) |-> $past(psel && penable && pwrite))
    else $error("cart kind changed without a register write");

endmodule

`default_nettype wire

@@ design/cbc_mapper.sv @@
`default_nettype none

module cbc_mapper
  import cbc_pkg::*;
#(
  parameter int unsigned ROM_BANK_BITS = RomBankBitsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire cbc_req_t   req_i,
  input  wire cart_kind_e cart_kind_i,
  output cbc_rsp_t        rsp_o
);

  localparam int unsigned BankW = (ROM_BANK_BITS < BankMaxW) ? ROM_BANK_BITS : BankMaxW;

  logic [BankW-1:0]    bank_q, bank_d;
  logic                ram_en_q, ram_en_d;
  bank_mode_e          mode_q, mode_d;
  logic [BankMaxW-1:0] bank7, bank7_d, bank_set;
  logic                bank_wr;
  logic                thru, fault;
  logic [RomAddrW-1:0] raddr;
  logic [2:0]          rgn;
  logic [AddrW-1:0]    a;
  logic [DataW-1:0]    d;
  logic                ram_key;

  assign a       = req_i.address;
  assign d       = req_i.write_data;
  assign rgn     = a[15:13];
  assign bank7   = BankMaxW'(bank_q);
  assign ram_key = (d[3:0] == RamEnKey);

  // write decode and next state
  always_comb begin
    thru     = 1'b0;
    ram_en_d = ram_en_q;
    mode_d   = mode_q;
    bank_wr  = 1'b0;
    bank_set = bank7;
    if (req_i.req_type == ReqWrite) begin
      case (cart_kind_i)
        KindRom: begin
          thru = 1'b1;
        end
        KindMbc1, KindMbc1Ram: begin
          case (rgn)
            RgnRamEn: begin
              if (cart_kind_i == KindMbc1Ram) ram_en_d = ram_key;
            end
            RgnBankLo: begin
              bank_wr  = 1'b1;
              bank_set = {bank7[6:5], (d[4:0] == 5'd0) ? 5'd1 : d[4:0]};
            end
            RgnBankHi: begin
              if (mode_q == ModeRom) begin
                bank_wr  = 1'b1;
                bank_set = {d[1:0], bank7[4:0]};
              end
            end
            RgnMode: begin
              mode_d = d[0] ? ModeRam : ModeRom;
            end
            default: begin
              thru = 1'b1;
            end
          endcase
        end
        KindMbc2, KindMbc2Bat: begin
          if (a[15:14] == 2'd0) begin
            if (!a[8]) begin
              ram_en_d = ram_key;
            end else begin
              bank_wr  = 1'b1;
              bank_set = {3'd0, (d[3:0] == 4'd0) ? 4'd1 : d[3:0]};
            end
          end else begin
            thru = 1'b1;
          end
        end
        KindMbc3, KindMbc3Ram: begin
          case (rgn)
            RgnRamEn: begin
              if (cart_kind_i == KindMbc3Ram) ram_en_d = ram_key;
            end
            RgnBankLo: begin
              bank_wr  = 1'b1;
              bank_set = (d[6:0] == 7'd0) ? 7'd1 : d[6:0];
            end
            RgnBankHi: begin
              if (d <= Mbc3ModeRamMax) mode_d = ModeRam;
              else if (d <= Mbc3ModeClockMax) mode_d = ModeClock;
            end
            RgnMode, RgnExtRam: begin
              thru = 1'b0;
            end
            default: begin
              thru = 1'b1;
            end
          endcase
        end
        default: begin
          thru = 1'b0;
        end
      endcase
    end
  end

  assign bank_d  = bank_wr ? BankW'(bank_set) : bank_q;
  assign bank7_d = BankMaxW'(bank_d);

  // read side: fault and physical address from the current bank
  always_comb begin
    fault = 1'b0;
    raddr = '0;
    if (req_i.req_type == ReqRead) begin
      if ((cart_kind_i inside {KindMbc1, KindMbc3}) && (rgn == RgnExtRam)) fault = 1'b1;
      if ((cart_kind_i == KindMbc2) && (a[15:9] == Mbc2RamTop)) fault = 1'b1;
      case (a[15:14])
        2'd0:    raddr = RomAddrW'(a);
        2'd1:    raddr = {bank7, a[13:0]};
        default: raddr = '0;
      endcase
    end
  end

  // bank state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= BankW'(1);
      ram_en_q <= 1'b0;
      mode_q   <= ModeRom;
    end else if (accept_i) begin
      bank_q   <= bank_d;
      ram_en_q <= ram_en_d;
      mode_q   <= mode_d;
    end
  end

  always_comb begin
    rsp_o.write_through   = thru;
    rsp_o.access_fault    = fault;
    rsp_o.rom_address     = raddr;
    rsp_o.rom_bank_now    = bank7_d;
    rsp_o.ram_enabled_now = ram_en_d;
    rsp_o.bank_mode_now   = mode_d;
  end

  a_read_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (req_i.req_type == ReqRead) |=>
      $stable(bank_q) && $stable(ram_en_q) && $stable(mode_q))
    else $error("read access changed bank state");

  a_thru_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && thru |=> $stable(bank_q) && $stable(ram_en_q) && $stable(mode_q))
    else $error("passed-through write changed bank state");

  a_ram_en_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ram_en_q) |-> ($past(cart_kind_i) == KindMbc1Ram) ||
      ($past(cart_kind_i) == KindMbc2) || ($past(cart_kind_i) == KindMbc2Bat) ||
      ($past(cart_kind_i) == KindMbc3Ram))
    else $error("ram enabled on a kind without ram enable register");

endmodule

`default_nettype wire
